// ===== rtl/core/u8250rf_pkg.sv =====
// Register map codes, bit positions and stream widths for the 8250-style UART register file.
package u8250rf_pkg;

    localparam int AddrWidth = 3;
    localparam int ByteWidth = 8;

    localparam logic [AddrWidth-1:0] ADDR_HOLD = 3'd0;
    localparam logic [AddrWidth-1:0] ADDR_IER  = 3'd1;
    localparam logic [AddrWidth-1:0] ADDR_IIR  = 3'd2;
    localparam logic [AddrWidth-1:0] ADDR_LCR  = 3'd3;
    localparam logic [AddrWidth-1:0] ADDR_MCR  = 3'd4;
    localparam logic [AddrWidth-1:0] ADDR_LSR  = 3'd5;
    localparam logic [AddrWidth-1:0] ADDR_MSR  = 3'd6;
    localparam logic [AddrWidth-1:0] ADDR_SCR  = 3'd7;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam int DlabBit = 7;

    localparam logic [ByteWidth-1:0] IIR_RESET = 8'h01;

    localparam int InDataWidth  = 24;
    localparam int InUserWidth  = 1 + AddrWidth;
    localparam int OutDataWidth = 24;

    typedef struct packed {
        logic                 rx_pop;
        logic [ByteWidth-1:0] tx_byte;
        logic                 tx_valid;
        logic [ByteWidth-1:0] read_data;
    } result_t;

endpackage

// ===== rtl/core/uart_8250_register_file.sv =====
// Top level of the 8250-style UART register file with a registered, skid-buffered result stream.
// Results are registered: a request's result reaches m_tdata through out_reg, or through skid_reg first on a stall.
// Throughput: one request per cycle; a two-entry output stage keeps s_tready high
// while one result waits on a stalled master side, and drops it once the skid stage also holds one.
// Reset: the UART registers and output valid flags clear to zero; the interrupt identification reads 0x01.
module uart_8250_register_file
    import u8250rf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // write_data[7:0], rx_byte[15:8], line_dcd[16], line_ri[17], line_dsr[18],
    // line_cts[19], zero[23:20]
    input  logic [InDataWidth-1:0]  s_tdata,
    // opcode[0], reg_address[3:1]
    input  logic [InUserWidth-1:0]  s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // read_data[7:0], tx_valid[8], tx_byte[16:9], rx_pop[17], zero[23:18]
    output logic [OutDataWidth-1:0] m_tdata
);

    logic [ByteWidth-1:0] dll_reg, dll_next;
    logic [ByteWidth-1:0] dlm_reg, dlm_next;
    logic [ByteWidth-1:0] ier_reg, ier_next;
    logic [ByteWidth-1:0] fcr_reg, fcr_next;
    logic [ByteWidth-1:0] lcr_reg, lcr_next;
    logic [ByteWidth-1:0] mcr_reg, mcr_next;
    logic [ByteWidth-1:0] lsr_reg, lsr_next;
    logic [ByteWidth-1:0] msr_reg, msr_next;
    logic [ByteWidth-1:0] scr_reg, scr_next;

    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t result;

    logic                 accept;
    logic                 is_write;
    logic [AddrWidth-1:0] addr;
    logic [ByteWidth-1:0] wdata;
    logic [ByteWidth-1:0] rxb;
    logic [3:0]           lines;
    logic [ByteWidth-1:0] msr_sample;
    logic                 dlab;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataWidth - $bits(result_t)){1'b0}}, out_reg};

    assign is_write   = (s_tuser[0] == OP_WRITE);
    assign addr       = s_tuser[AddrWidth:1];
    assign wdata      = s_tdata[7:0];
    assign rxb        = s_tdata[15:8];
    assign lines      = {s_tdata[16], s_tdata[17], s_tdata[18], s_tdata[19]};
    assign msr_sample = {lines, lines ^ msr_reg[7:4]};
    assign dlab       = lcr_reg[DlabBit];

    always_comb
    begin
        dll_next = dll_reg;
        dlm_next = dlm_reg;
        ier_next = ier_reg;
        fcr_next = fcr_reg;
        lcr_next = lcr_reg;
        mcr_next = mcr_reg;
        lsr_next = lsr_reg;
        msr_next = msr_reg;
        scr_next = scr_reg;
        result   = '0;
        if (is_write)
        begin
            unique case (addr)
                ADDR_HOLD:
                begin
                    if (dlab)
                    begin
                        dll_next = wdata;
                    end
                    else
                    begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = wdata;
                    end
                end
                ADDR_IER:
                begin
                    if (dlab)
                    begin
                        dlm_next = wdata;
                    end
                    else
                    begin
                        ier_next = wdata;
                    end
                end
                ADDR_IIR: fcr_next = wdata;
                ADDR_LCR: lcr_next = wdata;
                ADDR_MCR: mcr_next = wdata;
                ADDR_LSR: lsr_next = wdata;
                ADDR_MSR: msr_next = wdata;
                ADDR_SCR: scr_next = wdata;
                default:  scr_next = wdata;
            endcase
        end
        else
        begin
            unique case (addr)
                ADDR_HOLD:
                begin
                    if (dlab)
                    begin
                        result.read_data = dll_reg;
                    end
                    else
                    begin
                        result.read_data = rxb;
                        result.rx_pop    = 1'b1;
                    end
                end
                ADDR_IER: result.read_data = dlab ? dlm_reg : ier_reg;
                ADDR_IIR: result.read_data = IIR_RESET;
                ADDR_LCR: result.read_data = lcr_reg;
                ADDR_MCR: result.read_data = mcr_reg;
                ADDR_LSR: result.read_data = lsr_reg;
                ADDR_MSR:
                begin
                    msr_next         = msr_sample;
                    result.read_data = msr_sample;
                end
                ADDR_SCR: result.read_data = scr_reg;
                default:  result.read_data = scr_reg;
            endcase
        end
    end

    // Commit register updates on an accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dll_reg <= '0;
            dlm_reg <= '0;
            ier_reg <= '0;
            fcr_reg <= '0;
            lcr_reg <= '0;
            mcr_reg <= '0;
            lsr_reg <= '0;
            msr_reg <= '0;
            scr_reg <= '0;
        end
        else if (accept)
        begin
            dll_reg <= dll_next;
            dlm_reg <= dlm_next;
            ier_reg <= ier_next;
            fcr_reg <= fcr_next;
            lcr_reg <= lcr_next;
            mcr_reg <= mcr_next;
            lsr_reg <= lsr_next;
            msr_reg <= msr_next;
            scr_reg <= scr_next;
        end
    end

    // Advance the output register; park a result in the skid stage while stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (accept)
        begin
            skid_reg <= result;
        end
    end

endmodule
